### hw/rtl/aoc_pkg.sv
// Shared types and constants for the alpha-over compositing block.
`timescale 1ns / 1ps

package aoc_pkg;

  localparam int PIX_W     = 8;             // one colour or alpha channel
  localparam int WGT_W     = 16;            // sa*255, da*(255-sa) and their sum
  localparam int PROD_W    = PIX_W + WGT_W; // channel value times a weight
  localparam int NUM_W     = PROD_W + 1;    // 2*(sum of products) + weight sum
  localparam int DEN_W     = WGT_W + 1;     // twice the weight sum
  localparam int DIV_STEPS = PIX_W;         // one quotient bit per stage
  localparam int LANE_LAT  = DIV_STEPS + 2; // product stage, numerator stage, divider

  localparam int IN_TDATA_W  = 8 * PIX_W;
  localparam int OUT_TDATA_W = 4 * PIX_W;

  localparam logic [PIX_W-1:0] CHAN_MAX   = '1;
  // Half of 255, rounded down, turns the rounded alpha division into a floor.
  localparam logic [WGT_W-1:0] ALPHA_BIAS = WGT_W'(127);

  // Red sits in the lowest byte, alpha in the highest.
  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgba_t;

  // Information that bypasses the divider lanes.
  typedef struct packed {
    logic             empty;
    logic [PIX_W-1:0] dst_blue;
    logic [PIX_W-1:0] dst_green;
    logic [PIX_W-1:0] dst_red;
  } side_t;

endpackage

### hw/rtl/aoc_weight.sv
// Input register stage that forms the source and destination weights.
`timescale 1ns / 1ps

module aoc_weight (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  aoc_pkg::rgba_t             src,
  input  aoc_pkg::rgba_t             dst,
  output logic                       valid,
  output aoc_pkg::rgba_t             src_q,
  output logic [aoc_pkg::WGT_W-1:0]  ws,
  output logic [aoc_pkg::WGT_W-1:0]  wd,
  output logic [aoc_pkg::WGT_W-1:0]  wsum,
  output aoc_pkg::side_t             side
);
  import aoc_pkg::*;

  logic [PIX_W-1:0] inv;
  logic [WGT_W-1:0] ws_next;
  logic [WGT_W-1:0] wd_next;

  // sa*255 is a shift and a subtract; 255-sa is a bitwise inversion.
  always_comb begin
    inv     = CHAN_MAX - src.alpha;
    ws_next = {src.alpha, PIX_W'(0)} - {PIX_W'(0), src.alpha};
    wd_next = WGT_W'(dst.alpha) * WGT_W'(inv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src_q          <= src;
      ws             <= ws_next;
      wd             <= wd_next;
      wsum           <= ws_next + wd_next;
      side.empty     <= (src.alpha == '0) && (dst.alpha == '0);
      side.dst_red   <= dst.red;
      side.dst_green <= dst.green;
      side.dst_blue  <= dst.blue;
    end
  end

endmodule

### hw/rtl/aoc_lane.sv
// One compositing lane: weighted sum of two channels and a pipelined rounding divider.
`timescale 1ns / 1ps

module aoc_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [aoc_pkg::PIX_W-1:0]  xa,
  input  logic [aoc_pkg::PIX_W-1:0]  xb,
  input  logic [aoc_pkg::WGT_W-1:0]  wa,
  input  logic [aoc_pkg::WGT_W-1:0]  wb,
  input  logic [aoc_pkg::WGT_W-1:0]  den,
  output logic [aoc_pkg::PIX_W-1:0]  quot
);
  import aoc_pkg::*;

  logic [PROD_W-1:0] pa;
  logic [PROD_W-1:0] pb;
  logic [WGT_W-1:0]  den_p;

  // Restoring divider: rem[k] and dv[k] feed step k, q[k] holds the bits after it.
  logic [NUM_W-1:0] rem  [DIV_STEPS];
  logic [DEN_W-1:0] dv   [DIV_STEPS];
  logic [PIX_W-1:0] q    [DIV_STEPS];
  logic [NUM_W:0]   diff [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= PROD_W'(xa) * PROD_W'(wa);
      pb    <= PROD_W'(xb) * PROD_W'(wb);
      den_p <= den;
    end
  end

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      diff[k] = {1'b0, rem[k]} - ({1'b0, NUM_W'(dv[k])} << (DIV_STEPS - 1 - k));
    end
  end

  // Rounding to nearest, ties up: floor((2*num + den) / (2*den)).
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ((NUM_W'(pa) + NUM_W'(pb)) << 1) + NUM_W'(den_p);
      dv[0]  <= {den_p, 1'b0};
      q[0]   <= PIX_W'(~diff[0][NUM_W]);
      for (int k = 1; k < DIV_STEPS; k++) begin
        rem[k] <= diff[k-1][NUM_W] ? rem[k-1] : diff[k-1][NUM_W-1:0];
        dv[k]  <= dv[k-1];
        q[k]   <= {q[k-1][PIX_W-2:0], ~diff[k][NUM_W]};
      end
    end
  end

  assign quot = q[DIV_STEPS-1];

endmodule

### hw/rtl/aoc_merge.sv
// Bypass delay lines and output stage that combine the colour lanes with the alpha.
`timescale 1ns / 1ps

module aoc_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  aoc_pkg::side_t             side_in,
  input  logic [aoc_pkg::PIX_W-1:0]  alpha_in,
  input  logic [aoc_pkg::PIX_W-1:0]  quot_red,
  input  logic [aoc_pkg::PIX_W-1:0]  quot_green,
  input  logic [aoc_pkg::PIX_W-1:0]  quot_blue,
  input  logic                       clear_when_empty,
  output logic                       out_valid,
  output aoc_pkg::rgba_t             out_pix
);
  import aoc_pkg::*;

  logic             vld     [LANE_LAT];
  side_t            side_d  [LANE_LAT];
  logic [PIX_W-1:0] alpha_d [LANE_LAT];
  rgba_t            pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LANE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0]  <= side_in;
      alpha_d[0] <= alpha_in;
      for (int k = 1; k < LANE_LAT; k++) begin
        side_d[k]  <= side_d[k-1];
        alpha_d[k] <= alpha_d[k-1];
      end
      out_pix <= pix_next;
    end
  end

  // With both alphas zero the divider outputs are meaningless and are replaced.
  always_comb begin
    pix_next.red   = quot_red;
    pix_next.green = quot_green;
    pix_next.blue  = quot_blue;
    pix_next.alpha = alpha_d[LANE_LAT-1];
    if (side_d[LANE_LAT-1].empty) begin
      pix_next = '0;
      if (!clear_when_empty) begin
        pix_next.red   = side_d[LANE_LAT-1].dst_red;
        pix_next.green = side_d[LANE_LAT-1].dst_green;
        pix_next.blue  = side_d[LANE_LAT-1].dst_blue;
      end
    end
  end

endmodule

### hw/rtl/alpha_over_composite_core.sv
// Top level of the source-over-destination compositing block for RGBA8 pixels.
`timescale 1ns / 1ps

// The block takes one source and one destination pixel, both non-premultiplied,
// per transaction on the s_ channel and returns the composited pixel on the
// m_ channel. Colours are (sc*sa*255 + dc*da*(255-sa)) / D with
// D = sa*255 + da*(255-sa), and alpha is D / 255, all rounded to nearest with
// ties rounded up. Three colour lanes each run an 8-stage restoring divider that
// settles one quotient bit per stage; the alpha, a division by the constant 255,
// is a shift-and-add reciprocal that travels beside the lanes in a delay line.
// From the accepting edge to m_tvalid rising a pixel passes the weight stage,
// the product and numerator stages, eight divider stages and the output register.
// A new transaction can be accepted every cycle while the receiver keeps up, and
// the sustained rate is one pixel per clock, as every stage is fully pipelined.
// When both alphas are zero the output is cleared if clear_when_empty is set,
// otherwise the destination colour is passed through with alpha zero.
// clear_when_empty is written through cfg_we/cfg_wdata and should only be
// changed while no pixel is in flight.
// Reset (rst, synchronous, active high) empties the pipeline, drops m_tvalid
// and sets clear_when_empty. If the receiver stalls with a result waiting,
// the whole pipeline holds and s_tready falls until the result is taken.
module alpha_over_composite_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [aoc_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [aoc_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import aoc_pkg::*;

  logic             clear_when_empty;
  logic             en;
  rgba_t            src;
  rgba_t            dst;
  logic             w_valid;
  rgba_t            w_src;
  logic [WGT_W-1:0] ws;
  logic [WGT_W-1:0] wd;
  logic [WGT_W-1:0] wsum;
  side_t            side;
  side_t            w_side;
  logic [WGT_W-1:0] alpha_num;
  logic [WGT_W-1:0] alpha_sum;
  logic [PIX_W-1:0] alpha;
  logic [PIX_W-1:0] quot_red;
  logic [PIX_W-1:0] quot_green;
  logic [PIX_W-1:0] quot_blue;
  rgba_t            out_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_when_empty <= 1'b1;
    end else if (cfg_we) begin
      clear_when_empty <= cfg_wdata;
    end
  end

  // The pipeline moves as a whole whenever the output register is free or being emptied.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign src = s_tdata[OUT_TDATA_W-1:0];
  assign dst = s_tdata[IN_TDATA_W-1:OUT_TDATA_W];

  aoc_weight u_weight (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .src      (src),
    .dst      (dst),
    .valid    (w_valid),
    .src_q    (w_src),
    .ws       (ws),
    .wd       (wd),
    .wsum     (wsum),
    .side     (w_side)
  );

  // Colour lanes weight source and destination colour by ws and wd and divide by D.
  aoc_lane u_lane_red (
    .clk  (clk),
    .en   (en),
    .xa   (w_src.red),
    .xb   (w_side.dst_red),
    .wa   (ws),
    .wb   (wd),
    .den  (wsum),
    .quot (quot_red)
  );

  aoc_lane u_lane_green (
    .clk  (clk),
    .en   (en),
    .xa   (w_src.green),
    .xb   (w_side.dst_green),
    .wa   (ws),
    .wb   (wd),
    .den  (wsum),
    .quot (quot_green)
  );

  aoc_lane u_lane_blue (
    .clk  (clk),
    .en   (en),
    .xa   (w_src.blue),
    .xb   (w_side.dst_blue),
    .wa   (ws),
    .wb   (wd),
    .den  (wsum),
    .quot (quot_blue)
  );

  // D / 255 rounded to nearest equals floor((D + 127) / 255). The division by 255 is
  // the usual add-and-shift reciprocal, exact in 16 bits while the dividend is below 65280.
  assign alpha_num = wsum + ALPHA_BIAS;
  assign alpha_sum = alpha_num + (alpha_num >> PIX_W) + WGT_W'(1);
  assign alpha     = alpha_sum[WGT_W-1:PIX_W];

  assign side = w_side;

  aoc_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (w_valid),
    .side_in          (side),
    .alpha_in         (alpha),
    .quot_red         (quot_red),
    .quot_green       (quot_green),
    .quot_blue        (quot_blue),
    .clear_when_empty (clear_when_empty),
    .out_valid        (m_tvalid),
    .out_pix          (out_pix)
  );

  assign m_tdata = out_pix;

endmodule

### hw/rtl/aoc_checker.sv
// Port-level checks for the compositing block and their binding to the top level.
`timescale 1ns / 1ps

module aoc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [aoc_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  // A result that is not taken stays on the port unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // Nothing comes out in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");

  // The input side only stalls while a result is held back by the receiver.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled without a blocked result");

endmodule

bind alpha_over_composite_core aoc_checker u_aoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/tb.sv
// Self-checking testbench for the alpha-over compositing core.
`timescale 1ns / 1ps

module tb;
  import aoc_pkg::*;

  // One input transaction: the source pixel in the low 32 bits, the destination above it.
  typedef struct packed {
    rgba_t dst;
    rgba_t src;
  } pixel_pair_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Composited pixels still owed by the block, oldest first.
  rgba_t       owed_pixels[$];
  // Our own copy of the clear-when-empty register; it comes out of reset set.
  bit          clear_empty_mode = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  string       chan_name[4] = '{"red", "green", "blue", "alpha"};

  alpha_over_composite_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Nearest integer quotient, ties rounded up.
  function automatic logic [PIX_W-1:0] round_quot(int unsigned num, int unsigned den);
    return PIX_W'((2 * num + den) / (2 * den));
  endfunction

  // Source-over-destination for non-premultiplied pixels. The weights are the source
  // alpha times 255 and the destination alpha times the source's transparency, so
  // the arithmetic stays exact in integers.
  function automatic rgba_t blend_over(rgba_t src, rgba_t dst, bit clear_empty);
    int unsigned src_wgt;
    int unsigned dst_wgt;
    int unsigned total;
    rgba_t       res;
    src_wgt = int'(src.alpha) * 255;
    dst_wgt = int'(dst.alpha) * (255 - int'(src.alpha));
    total   = src_wgt + dst_wgt;
    if (total == 0) begin
      // Both alphas are zero: either a cleared pixel or the destination as it stands.
      res = clear_empty ? rgba_t'('0) : dst;
    end else begin
      res.red   = round_quot(src.red * src_wgt + dst.red * dst_wgt, total);
      res.green = round_quot(src.green * src_wgt + dst.green * dst_wgt, total);
      res.blue  = round_quot(src.blue * src_wgt + dst.blue * dst_wgt, total);
      res.alpha = round_quot(total, 255);
    end
    return res;
  endfunction

  function automatic pixel_pair_t make_pair(
    logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] sa,
    logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da
  );
    pixel_pair_t p;
    p.src = '{alpha: sa, blue: sb, green: sg, red: sr};
    p.dst = '{alpha: da, blue: db, green: dg, red: dr};
    return p;
  endfunction

  // Alphas lean towards the corners of their range, where the weights degenerate;
  // colours are mostly uniform with a share of full-scale values.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 3));
      3:       return 8'($urandom_range(252, 254));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    p = make_pair(pick_colour(), pick_colour(), pick_colour(), pick_alpha(),
                  pick_colour(), pick_colour(), pick_colour(), pick_alpha());
    // Force the empty case now and then so both register settings see plenty of it.
    if ($urandom_range(0, 19) == 0) begin
      p.src.alpha = 8'd0;
      p.dst.alpha = 8'd0;
    end
    return p;
  endfunction

  // Offer one pixel pair and return once the block has taken it. The sender runs in
  // bursts; between bursts tvalid may drop for a random gap, sometimes a long one.
  task automatic send_pixel(pixel_pair_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0:       gap = 0;
        1:       gap = $urandom_range(10, 25);
        default: gap = $urandom_range(1, 6);
      endcase
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    owed_pixels = {owed_pixels, blend_over(p.src, p.dst, clear_empty_mode)};
  endtask

  // Hold the sender off until every owed pixel has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_pixels.size() != 0) @(posedge clk);
  endtask

  // The register is only touched with the pipeline empty and settled.
  task automatic write_clear_mode(bit value);
    wait_drained();
    repeat (LANE_LAT + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clear_empty_mode = value;
  endtask

  // Straight after reset the block must clear pixels whose alphas are both zero.
  task automatic test_default_clear();
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pair(8'd200, 8'd100, 8'd50, 8'd0, 8'd12, 8'd34, 8'd56, 8'd0));
    send_pixel(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
  endtask

  // Opaque and fully transparent sources, alphas one step from the ends, and two pairs
  // whose source and destination weights are equal so the colour lands on a half.
  task automatic test_alpha_extremes();
    send_pixel(make_pair(8'd10, 8'd20, 8'd30, 8'd255, 8'd200, 8'd210, 8'd220, 8'd255));
    send_pixel(make_pair(8'd255, 8'd0, 8'd128, 8'd255, 8'd1, 8'd2, 8'd3, 8'd0));
    send_pixel(make_pair(8'd90, 8'd91, 8'd92, 8'd0, 8'd255, 8'd128, 8'd0, 8'd255));
    send_pixel(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd7, 8'd8, 8'd9, 8'd1));
    send_pixel(make_pair(8'd255, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255));
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd254, 8'd255, 8'd255, 8'd255, 8'd1));
    send_pixel(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd128));
    // Source alpha 102 and destination alpha 170 give equal weights of 26010.
    send_pixel(make_pair(8'd1, 8'd0, 8'd3, 8'd102, 8'd0, 8'd1, 8'd0, 8'd170));
    send_pixel(make_pair(8'd254, 8'd255, 8'd100, 8'd102, 8'd255, 8'd254, 8'd101, 8'd170));
  endtask

  // With the register cleared, empty pixels pass the destination colour through; then it is set again.
  task automatic test_passthrough_setting();
    write_clear_mode(1'b0);
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
    send_pixel(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd170, 8'd85, 8'd0));
    send_pixel(make_pair(8'd40, 8'd50, 8'd60, 8'd0, 8'd70, 8'd80, 8'd90, 8'd1));
    write_clear_mode(1'b1);
    send_pixel(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0));
  endtask

  // Random traffic in phases that alternate the register, with the odd pause in
  // which the sender waits for the pipeline to empty completely.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_clear_mode(phase[0] ? 1'b1 : 1'b0);
      for (int n = 0; n < 320; n++) begin
        if ($urandom_range(0, 149) == 0) wait_drained();
        send_pixel(random_pair());
      end
    end
  endtask

  // The receiver changes its manner every so often: always ready, ready half of the
  // time, rarely stalling, or stalling for long stretches.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 7) != 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Every result transaction is matched against the oldest owed pixel, channel by channel.
  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, got);
        mismatch_count++;
      end else begin
        want = owed_pixels.pop_front();
        for (int c = 0; c < 4; c++) begin
          if (got[8*c +: 8] !== want[8*c +: 8]) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, chan_name[c],
                     want[8*c +: 8], got[8*c +: 8]);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_clear();
    test_alpha_extremes();
    test_passthrough_setting();
    test_random_traffic();
    wait_drained();
    // Any stray result still in the pipeline would show up within this window.
    repeat (LANE_LAT + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/aoc_pkg.sv
hw/rtl/aoc_weight.sv
hw/rtl/aoc_lane.sv
hw/rtl/aoc_merge.sv
hw/rtl/alpha_over_composite_core.sv
hw/rtl/aoc_checker.sv
dv/tb.sv
